FILE: src/ps2md_pkg.sv
// ps2md_pkg: shared types and constants for the PS/2 mouse packet decoder.
// No dependencies.
package ps2md_pkg;

   typedef enum logic [1:0] {
      REG_ENABLE      = 2'd0,
      REG_WHEEL_MODE  = 2'd1,
      REG_CLAMP_LIMIT = 2'd2
   } reg_index_type;

   localparam logic [7:0] HDR_ALWAYS_ONE = 8'h08;
   localparam logic [7:0] HDR_OVERFLOW   = 8'hC0;
   localparam logic [7:0] HDR_X_SIGN     = 8'h10;
   localparam logic [7:0] HDR_Y_SIGN     = 8'h20;
   localparam logic [7:0] HDR_BUTTONS    = 8'h07;
   localparam logic [7:0] CLAMP_RESET    = 8'd50;

   localparam logic EVT_MOVE   = 1'b0;
   localparam logic EVT_BUTTON = 1'b1;

   typedef struct packed {
      logic              event_kind;
      logic signed [8:0] move_x;
      logic signed [8:0] move_y;
      logic [2:0]        buttons;
      logic              last_of_run;
   } result_type;

endpackage

FILE: src/ps2_mouse_packet_decoder.sv
// ps2_mouse_packet_decoder: assembles 3- or 4-byte PS/2 mouse packets into
// move and button items. Depends on ps2md_pkg.
// A completing byte writes its results into the result queue as it is accepted.
// Throughput: one byte per cycle while the 4-entry result queue holds two or
// fewer items; a byte yields up to two results, and the queue drains one
// result per cycle while rsp_stall is low.
// Reset (synchronous): config to defaults, packet position and reported
// buttons to zero, result queue empty.
module ps2_mouse_packet_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_aux_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_event_kind,
   output logic signed [8:0] rsp_move_x,
   output logic signed [8:0] rsp_move_y,
   output logic              rsp_left_button,
   output logic              rsp_right_button,
   output logic              rsp_middle_button,
   output logic              rsp_last_of_run,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   localparam int FifoDepth = 4;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = $clog2(FifoDepth + 1);

   logic       enable_ff, enable_in;
   logic       wheel_ff, wheel_in;
   logic [7:0] limit_ff, limit_in;
   logic [1:0] pos_ff, pos_in;
   logic [2:0] btn_ff, btn_in;
   logic [7:0] hdr_ff, hdr_in;
   logic [7:0] x_ff, x_in;
   logic [7:0] y_ff, y_in;

   ps2md_pkg::result_type fifo_ff [FifoDepth];
   logic [PtrW-1:0] head_ff, head_in;
   logic [PtrW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;

   logic                  accept, pop, complete, mv_hit, btn_evt;
   logic [1:0]            push_n;
   logic [2:0]            pos_next;
   logic [7:0]            y_byte;
   logic signed [9:0]     dx, dy, lim, nlim;
   logic signed [8:0]     cx, cy;
   ps2md_pkg::result_type r_move, r_btn, r0, r1;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff > CntW'(FifoDepth - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      enable_in = enable_ff;
      wheel_in  = wheel_ff;
      limit_in  = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ps2md_pkg::REG_ENABLE:      enable_in = csr_wdata[0];
            ps2md_pkg::REG_WHEEL_MODE:  wheel_in  = csr_wdata[0];
            ps2md_pkg::REG_CLAMP_LIMIT: limit_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // packet assembly
   always_comb begin
      pos_in   = pos_ff;
      hdr_in   = hdr_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      complete = 1'b0;
      pos_next = {1'b0, pos_ff} + 3'd1;
      if (accept && enable_ff) begin
         if (pos_ff == 2'd0) begin
            if ((req_aux_byte & ps2md_pkg::HDR_ALWAYS_ONE) != 8'h00 &&
                (req_aux_byte & ps2md_pkg::HDR_OVERFLOW) == 8'h00) begin
               hdr_in = req_aux_byte;
               pos_in = 2'd1;
            end
         end else begin
            if (pos_ff == 2'd1) x_in = req_aux_byte;
            if (pos_ff == 2'd2) y_in = req_aux_byte;
            if (pos_next < (wheel_ff ? 3'd4 : 3'd3)) begin
               pos_in = pos_next[1:0];
            end else begin
               pos_in   = 2'd0;
               complete = 1'b1;
            end
         end
      end
   end

   // delta decode and clamp
   always_comb begin
      y_byte = (pos_ff == 2'd2) ? req_aux_byte : y_ff;
      dx   = 10'(signed'({((hdr_ff & ps2md_pkg::HDR_X_SIGN) != 8'h00), x_ff}));
      dy   = 10'(signed'({((hdr_ff & ps2md_pkg::HDR_Y_SIGN) != 8'h00), y_byte}));
      lim  = signed'({2'b00, limit_ff});
      nlim = -lim;
      if (dx > lim)       cx = lim[8:0];
      else if (dx < nlim) cx = nlim[8:0];
      else                cx = dx[8:0];
      if (dy > lim)       cy = lim[8:0];
      else if (dy < nlim) cy = nlim[8:0];
      else                cy = dy[8:0];
   end

   always_comb begin
      mv_hit   = complete && (cx != 9'sd0 || cy != 9'sd0);
      btn_evt  = complete && ((hdr_ff & ps2md_pkg::HDR_BUTTONS) != {5'd0, btn_ff});
      btn_in   = btn_evt ? hdr_ff[2:0] : btn_ff;

      r_move.event_kind  = ps2md_pkg::EVT_MOVE;
      r_move.move_x      = cx;
      r_move.move_y      = -cy;
      r_move.buttons     = 3'd0;
      r_move.last_of_run = !btn_evt;

      r_btn.event_kind  = ps2md_pkg::EVT_BUTTON;
      r_btn.move_x      = 9'sd0;
      r_btn.move_y      = 9'sd0;
      r_btn.buttons     = hdr_ff[2:0];
      r_btn.last_of_run = 1'b1;

      r0     = mv_hit ? r_move : r_btn;
      r1     = r_btn;
      push_n = {1'b0, mv_hit} + {1'b0, btn_evt};
   end

   always_comb begin
      head_in  = pop ? head_ff + PtrW'(1) : head_ff;
      tail_in  = tail_ff + PtrW'(push_n);
      count_in = count_ff + CntW'(push_n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         wheel_ff  <= 1'b0;
         limit_ff  <= ps2md_pkg::CLAMP_RESET;
         pos_ff    <= 2'd0;
         btn_ff    <= 3'd0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         wheel_ff  <= wheel_in;
         limit_ff  <= limit_in;
         pos_ff    <= pos_in;
         btn_ff    <= btn_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      if (push_n != 2'd0) fifo_ff[tail_ff] <= r0;
      if (push_n == 2'd2) fifo_ff[tail_ff + PtrW'(1)] <= r1;
   end

   assign rsp_event_kind    = fifo_ff[head_ff].event_kind;
   assign rsp_move_x        = fifo_ff[head_ff].move_x;
   assign rsp_move_y        = fifo_ff[head_ff].move_y;
   assign rsp_left_button   = fifo_ff[head_ff].buttons[0];
   assign rsp_right_button  = fifo_ff[head_ff].buttons[1];
   assign rsp_middle_button = fifo_ff[head_ff].buttons[2];
   assign rsp_last_of_run   = fifo_ff[head_ff].last_of_run;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(FifoDepth))
      else $error("result queue overflow");

   a_move_no_buttons: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == ps2md_pkg::EVT_MOVE |->
      !rsp_left_button && !rsp_right_button && !rsp_middle_button)
      else $error("move item carries button bits");

   a_disabled_holds: assert property (@(posedge clock) disable iff (reset)
      accept && !enable_ff && !(csr_valid && csr_index == ps2md_pkg::REG_ENABLE)
      |=> $stable(pos_ff) && $stable(btn_ff))
      else $error("state changed while disabled");

   a_move_then_button: assert property (@(posedge clock) disable iff (reset)
      mv_hit && btn_evt |-> push_n == 2'd2 && !r0.last_of_run)
      else $error("two results not queued in order");

endmodule
